FILE: rtl/srecord_to_load_commands_core_defines.svh
// ----------------------------------------------------------------------------
// S-record to loader command converter: assertion macros
// Shared assertion helpers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SRECORD_TO_LOAD_COMMANDS_CORE_DEFINES_SVH
`define SRECORD_TO_LOAD_COMMANDS_CORE_DEFINES_SVH
`ifndef SYNTH
`define SRTLC_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SRTLC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SRTLC_ASSERT(lbl, ante, cons, msg)
`define SRTLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: rtl/srtlc_pkg.sv
// ----------------------------------------------------------------------------
// S-record to loader command converter: package
// Character codes, line positions, parser state and result word types.
// ----------------------------------------------------------------------------
package srtlc_pkg;

	localparam logic [7:0] CH_LF         = 8'h0A;
	localparam logic [7:0] CH_CR         = 8'h0D;
	localparam logic [7:0] CH_S          = 8'h53;
	localparam logic [7:0] CH_TYPE_DATA  = 8'h31;
	localparam logic [7:0] CH_TYPE_END   = 8'h39;
	localparam logic [7:0] CMD_RAM       = 8'h57;
	localparam logic [7:0] CMD_EEPROM    = 8'h50;
	localparam logic [7:0] COUNT_OFFSET  = 8'd3;

	localparam int         ADDR_W              = 3;
	localparam logic [2:0] REG_TARGET_EEPROM   = 3'd0;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	typedef enum logic [11:0] {
		POS_START     = 12'b0000_0000_0001,
		POS_TYPE      = 12'b0000_0000_0010,
		POS_COUNT_HI  = 12'b0000_0000_0100,
		POS_COUNT_LO  = 12'b0000_0000_1000,
		POS_ADRH_HI   = 12'b0000_0001_0000,
		POS_ADRH_LO   = 12'b0000_0010_0000,
		POS_ADRL_HI   = 12'b0000_0100_0000,
		POS_ADRL_LO   = 12'b0000_1000_0000,
		POS_COUNT_OUT = 12'b0001_0000_0000,
		POS_DATA_LO   = 12'b0010_0000_0000,
		POS_DATA_HI   = 12'b0100_0000_0000,
		POS_SKIP      = 12'b1000_0000_0000
	} pos_t;

	typedef struct packed {
		pos_t       pos;
		logic       active;
		logic [3:0] high_nib;
		logic       nib_bad;
		logic [7:0] data_left;
		logic       count_bad;
		logic       file_done;
	} st_t;

	localparam st_t ST_RESET = '{
		pos: POS_START, active: 1'b0, high_nib: 4'd0, nib_bad: 1'b0,
		data_left: 8'd0, count_bad: 1'b0, file_done: 1'b0
	};

	typedef struct packed {
		logic [7:0] data;
		logic       bad;
		logic       eof;
		logic       last;
	} res_t;

	// Returns {illegal, value}; an illegal digit reads as zero.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end else begin
			r = 5'b1_0000;
		end
		return r;
	endfunction

endpackage

FILE: rtl/srtlc_decode.sv
// ----------------------------------------------------------------------------
// S-record to loader command converter: character decoder
// Next parser state and up to two result words for one text character.
// ----------------------------------------------------------------------------
module srtlc_decode (
	input  logic [7:0]      ch,
	input  logic            target_eeprom,
	input  srtlc_pkg::st_t  st,
	output srtlc_pkg::st_t  st_next,
	output srtlc_pkg::res_t res0,
	output srtlc_pkg::res_t res1,
	output logic [1:0]      res_cnt
);

	logic [4:0] hv;
	logic [3:0] nib;
	logic       dig_bad;
	logic [7:0] pair;
	logic       pair_bad;
	logic [7:0] left_dec;

	assign hv       = srtlc_pkg::hex_value(ch);
	assign nib      = hv[3:0];
	assign dig_bad  = hv[4];
	assign pair     = {st.high_nib, nib};
	assign pair_bad = st.nib_bad | dig_bad;
	assign left_dec = st.data_left - 8'd1;

	always_comb begin
		st_next = st;
		res0    = '0;
		res1    = '0;
		res_cnt = 2'd0;
		if (st.file_done) begin
			res_cnt = 2'd0;
		end else if (ch == srtlc_pkg::CH_LF || ch == srtlc_pkg::CH_CR) begin
			if (st.active && st.pos == srtlc_pkg::POS_COUNT_OUT) begin
				res0.data = st.data_left;
				res0.bad  = st.count_bad;
				res_cnt   = 2'd1;
			end
			st_next.pos    = srtlc_pkg::POS_START;
			st_next.active = 1'b0;
		end else if (!st.active) begin
			if (st.pos == srtlc_pkg::POS_START) begin
				st_next.pos = (ch == srtlc_pkg::CH_S) ? srtlc_pkg::POS_TYPE
					: srtlc_pkg::POS_SKIP;
			end else if (st.pos == srtlc_pkg::POS_TYPE) begin
				if (ch == srtlc_pkg::CH_TYPE_END) begin
					st_next.file_done = 1'b1;
					st_next.pos       = srtlc_pkg::POS_SKIP;
					res0.eof          = 1'b1;
					res_cnt           = 2'd1;
				end else if (ch == srtlc_pkg::CH_TYPE_DATA) begin
					st_next.active = 1'b1;
					st_next.pos    = srtlc_pkg::POS_COUNT_HI;
				end else begin
					st_next.pos = srtlc_pkg::POS_SKIP;
				end
			end
		end else begin
			case (st.pos)
				srtlc_pkg::POS_COUNT_HI: begin
					st_next.high_nib = nib;
					st_next.nib_bad  = dig_bad;
					st_next.pos      = srtlc_pkg::POS_COUNT_LO;
				end
				srtlc_pkg::POS_ADRH_HI: begin
					st_next.high_nib = nib;
					st_next.nib_bad  = dig_bad;
					st_next.pos      = srtlc_pkg::POS_ADRH_LO;
				end
				srtlc_pkg::POS_ADRL_HI: begin
					st_next.high_nib = nib;
					st_next.nib_bad  = dig_bad;
					st_next.pos      = srtlc_pkg::POS_ADRL_LO;
				end
				srtlc_pkg::POS_DATA_HI: begin
					st_next.high_nib = nib;
					st_next.nib_bad  = dig_bad;
					st_next.pos      = srtlc_pkg::POS_DATA_LO;
				end
				srtlc_pkg::POS_COUNT_LO: begin
					st_next.count_bad = pair_bad;
					st_next.data_left = (pair > srtlc_pkg::COUNT_OFFSET)
						? pair - srtlc_pkg::COUNT_OFFSET : 8'd0;
					st_next.pos       = srtlc_pkg::POS_ADRH_HI;
				end
				srtlc_pkg::POS_ADRH_LO: begin
					res0.data   = target_eeprom ? srtlc_pkg::CMD_EEPROM : srtlc_pkg::CMD_RAM;
					res1.data   = pair;
					res1.bad    = pair_bad;
					res_cnt     = 2'd2;
					st_next.pos = srtlc_pkg::POS_ADRL_HI;
				end
				srtlc_pkg::POS_ADRL_LO: begin
					res0.data   = pair;
					res0.bad    = pair_bad;
					res_cnt     = 2'd2;
					st_next.pos = srtlc_pkg::POS_COUNT_OUT;
				end
				srtlc_pkg::POS_COUNT_OUT: begin
					res0.data = st.data_left;
					res0.bad  = st.count_bad;
					res_cnt   = 2'd1;
					if (st.data_left == 8'd0) begin
						st_next.active = 1'b0;
						st_next.pos    = srtlc_pkg::POS_SKIP;
					end else begin
						st_next.high_nib = nib;
						st_next.nib_bad  = dig_bad;
						st_next.pos      = srtlc_pkg::POS_DATA_LO;
					end
				end
				srtlc_pkg::POS_DATA_LO: begin
					res0.data         = pair;
					res0.bad          = pair_bad;
					res_cnt           = 2'd1;
					st_next.data_left = left_dec;
					if (left_dec == 8'd0) begin
						st_next.active = 1'b0;
						st_next.pos    = srtlc_pkg::POS_SKIP;
					end else begin
						st_next.pos = srtlc_pkg::POS_DATA_HI;
					end
				end
				default: begin
					st_next.active = 1'b0;
					st_next.pos    = srtlc_pkg::POS_SKIP;
				end
			endcase
		end
		if (res_cnt == 2'd1) begin
			res0.last = 1'b1;
		end
		if (res_cnt == 2'd2) begin
			res1.last = 1'b1;
		end
	end

endmodule

FILE: rtl/srtlc_fifo.sv
// ----------------------------------------------------------------------------
// S-record to loader command converter: result queue
// Small queue that takes up to two result words per cycle and gives one.
// ----------------------------------------------------------------------------
`include "srecord_to_load_commands_core_defines.svh"

module srtlc_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      push_cnt,
	input  srtlc_pkg::res_t                 push0,
	input  srtlc_pkg::res_t                 push1,
	input  logic                            pop,
	output srtlc_pkg::res_t                 head,
	output logic [srtlc_pkg::FIFO_CW-1:0]   cnt
);

	srtlc_pkg::res_t                 mem [srtlc_pkg::FIFO_DEPTH];
	logic [srtlc_pkg::FIFO_AW-1:0]   wp_q;
	logic [srtlc_pkg::FIFO_AW-1:0]   rp_q;
	logic [srtlc_pkg::FIFO_CW-1:0]   cnt_q;
	logic [srtlc_pkg::FIFO_AW-1:0]   wp_inc;

	assign wp_inc = wp_q + srtlc_pkg::FIFO_AW'(1);
	assign head   = mem[rp_q];
	assign cnt    = cnt_q;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wp_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			mem[wp_inc] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + srtlc_pkg::FIFO_AW'(push_cnt);
			rp_q  <= rp_q + srtlc_pkg::FIFO_AW'(pop);
			cnt_q <= cnt_q + srtlc_pkg::FIFO_CW'(push_cnt) - srtlc_pkg::FIFO_CW'(pop);
		end
	end

	`SRTLC_ASSERT(a_fifo_no_overflow, push_cnt != 2'd0, (cnt_q + srtlc_pkg::FIFO_CW'(push_cnt)) <= srtlc_pkg::FIFO_CW'(srtlc_pkg::FIFO_DEPTH), "Result queue overflow.")
	`SRTLC_ASSERT(a_fifo_ptr_empty, cnt_q == '0, rp_q == wp_q, "Queue pointers disagree while empty.")

endmodule

FILE: rtl/srecord_to_load_commands_core.sv
// ----------------------------------------------------------------------------
// S-record to loader command converter
// Turns S-record text, one character per word, into loader command bytes.
// ----------------------------------------------------------------------------
// A character is accepted into an input register and decoded from it; its
// result words are written into the result queue, whose head is offered.
// One character is taken per cycle while the result queue has room for two
// words; the output side moves one word per cycle while out_stall is low,
// so characters that cause two words drain at one word per cycle.
// Reset clears the parser to the start of a line and selects RAM writes.
`include "srecord_to_load_commands_core_defines.svh"

module srecord_to_load_commands_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [srtlc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    ascii_char,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_byte,
	output logic                          bad_digit,
	output logic                          end_of_file,
	output logic                          last
);

	logic                          target_q;
	logic                          s1_valid;
	logic [7:0]                    ch_s1;
	srtlc_pkg::st_t                st_q;
	srtlc_pkg::st_t                st_next;
	srtlc_pkg::res_t               res0;
	srtlc_pkg::res_t               res1;
	srtlc_pkg::res_t               head;
	logic [1:0]                    dec_cnt;
	logic [srtlc_pkg::FIFO_CW-1:0] fifo_cnt;
	logic                          room;
	logic                          s1_adv;
	logic                          in_acc;
	logic                          pop;

	assign pready = 1'b1;
	assign prdata = (paddr == srtlc_pkg::REG_TARGET_EEPROM) ? {31'd0, target_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == srtlc_pkg::REG_TARGET_EEPROM) begin
			target_q <= pwdata[0];
		end
	end

	assign room     = fifo_cnt <= srtlc_pkg::FIFO_CW'(srtlc_pkg::FIFO_DEPTH - 2);
	assign s1_adv   = s1_valid && room;
	assign in_stall = s1_valid && !room;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			st_q     <= srtlc_pkg::ST_RESET;
		end else begin
			s1_valid <= in_acc || (s1_valid && !s1_adv);
			if (s1_adv) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_s1 <= ascii_char;
		end
	end

	srtlc_decode u_decode (
		.ch            (ch_s1),
		.target_eeprom (target_q),
		.st            (st_q),
		.st_next       (st_next),
		.res0          (res0),
		.res1          (res1),
		.res_cnt       (dec_cnt)
	);

	assign out_valid = fifo_cnt != '0;
	assign pop       = out_valid && !out_stall;

	srtlc_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cnt (s1_adv ? dec_cnt : 2'd0),
		.push0    (res0),
		.push1    (res1),
		.pop      (pop),
		.head     (head),
		.cnt      (fifo_cnt)
	);

	assign out_byte    = head.data;
	assign bad_digit   = head.bad;
	assign end_of_file = head.eof;
	assign last        = head.last;

	`SRTLC_ASSERT(a_eof_quiet, s1_adv && st_q.file_done, dec_cnt == 2'd0, "Result after end of file.")
	`SRTLC_ASSERT_NEXT(a_eof_sticky, st_q.file_done, st_q.file_done, "End of file mark was lost.")
	`SRTLC_ASSERT(a_active_pos, st_q.active, st_q.pos != srtlc_pkg::POS_START && st_q.pos != srtlc_pkg::POS_TYPE && st_q.pos != srtlc_pkg::POS_SKIP, "Active record at a non-record position.")
	`SRTLC_ASSERT(a_pair_no_eof, dec_cnt == 2'd2, !res0.eof && !res1.eof, "End of file word in a pair.")

endmodule
